>>> rtl/bbpc_pkg.sv
// Shared types and constants for the two-beam passage counter.
package bbpc_pkg;

  // Item kinds carried on the input side-band
  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_SCAN = 1'b1
  } op_t;

  // Configuration register indexes
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_STALE  = 1'b1;

  localparam logic [31:0] WINDOW_RESET = 32'd2000;
  localparam logic [31:0] STALE_RESET  = 32'd5000;

  typedef struct packed {
    logic [7:0]  levels_inner;
    logic [7:0]  levels_outer;
    logic [7:0]  flags_inner;
    logic [7:0]  flags_outer;
    logic [31:0] now;
    op_t         opcode;
  } item_t;

  typedef struct packed {
    logic [7:0]  dropped_inner;
    logic [7:0]  dropped_outer;
    logic [31:0] bee_count;
  } res_t;

  // Top level to sequencer
  typedef struct packed {
    logic start;
    logic take;
  } ctl_t;

  // Sequencer to top level
  typedef struct packed {
    logic idle;
    logic done;
  } stat_t;

endpackage

>>> rtl/bidirectional_beam_pair_counter_core.sv
// Two-beam passage counter: stream ports, configuration and result register.
// Flow: an accepted beat closes the input until its walk ends and its result is taken
// into the result register; an edge beat walks both FIFOs of every channel, a scan beat
// every channel's heads through the timestamp memory and the shared subtract-compare unit.
// Reset (rst, synchronous) empties every FIFO, clears the count and loads the
// window and timeout registers with 2000 and 5000; no clearing pass is needed.
module bidirectional_beam_pair_counter_core import bbpc_pkg::*; #(
  parameter int QUEUE_DEPTH = 5,
  parameter int CHANNELS    = 8,
  parameter int TICK_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now[31:0], flags_outer[39:32], flags_inner[47:40],
  // levels_outer[55:48], levels_inner[63:56]
  input  logic [63:0] s_tdata,
  // opcode[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // bee_count[31:0], dropped_outer[39:32], dropped_inner[47:40]
  output logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] window;
  logic [31:0] stale;
  item_t       item;
  ctl_t        ctl;
  stat_t       stat;
  res_t        res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
      stale  <= STALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW: window <= cfg_data;
        REG_STALE:  stale  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Unpack the input beat
  assign item.opcode       = op_t'(s_tuser[0]);
  assign item.now          = s_tdata[31:0];
  assign item.flags_outer  = s_tdata[39:32];
  assign item.flags_inner  = s_tdata[47:40];
  assign item.levels_outer = s_tdata[55:48];
  assign item.levels_inner = s_tdata[63:56];

  assign s_tready  = stat.idle;
  assign ctl.start = s_tvalid & s_tready;
  assign ctl.take  = stat.done & (~m_tvalid | m_tready);

  bbpc_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .CHANNELS   (CHANNELS),
    .TICK_BITS  (TICK_BITS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .item  (item),
    .window(window),
    .stale (stale),
    .stat  (stat),
    .res   (res)
  );

  // Result register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      m_tdata <= {res.dropped_inner, res.dropped_outer, res.bee_count};
    end
  end

  // An accepted beat starts the walk, so the input closes next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after an accepted beat");

  // A finished walk always lands in the result register
  a_take_loads_result: assert property (@(posedge clk) disable iff (rst)
    ctl.take |=> m_tvalid)
    else $error("finished result not presented");

  // Only existing channels can report a drop
  a_drop_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[39:32] >> CHANNELS) == 8'd0) &&
                 ((m_tdata[47:40] >> CHANNELS) == 8'd0))
    else $error("drop flagged on a channel that does not exist");

endmodule

>>> rtl/bbpc_ssub.sv
// Shared subtract-and-compare unit: modular difference, order and limit test.
module bbpc_ssub import bbpc_pkg::*; #(
  parameter int TICK_BITS = 32
) (
  input  logic [TICK_BITS-1:0] a,
  input  logic [TICK_BITS-1:0] b,
  input  logic [31:0]          lim,
  output logic                 borrow,
  output logic                 exceeds
);

  localparam int LW = (TICK_BITS > 32) ? TICK_BITS : 32;

  logic [TICK_BITS-1:0] diff;

  // Subtract with borrow; borrow means a < b
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

  // Difference modulo the tick range against the limit
  assign exceeds = LW'(diff) > LW'(lim);

endmodule

>>> rtl/bbpc_seq.sv
// Sequencer: event FIFOs, their storage and the edge and scan walks.
module bbpc_seq import bbpc_pkg::*; #(
  parameter int QUEUE_DEPTH = 5,
  parameter int CHANNELS    = 8,
  parameter int TICK_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  input  item_t       item,
  input  logic [31:0] window,
  input  logic [31:0] stale,
  output stat_t       stat,
  output res_t        res
);

  localparam int FIFOS = 2 * CHANNELS;
  localparam int DEPTH = FIFOS * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FXW   = $clog2(FIFOS);
  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int PW    = $clog2(2 * QUEUE_DEPTH);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WB    = (TICK_BITS > 32) ? TICK_BITS : 32;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EDGE = 9'b000000010,
    S_RDO  = 9'b000000100,
    S_RDI  = 9'b000001000,
    S_ORD  = 9'b000010000,
    S_GAP  = 9'b000100000,
    S_AGEO = 9'b001000000,
    S_AGEI = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t               state;
  logic [CW-1:0]        ch;
  logic                 side;
  item_t                item_q;
  logic                 lt;
  logic [TICK_BITS-1:0] to_q;
  logic [TICK_BITS-1:0] rdata;
  logic [7:0]           drop_o;
  logic [7:0]           drop_i;
  logic [31:0]          total;
  logic [QW-1:0]        head_o [CHANNELS];
  logic [QW-1:0]        head_i [CHANNELS];
  logic [FW-1:0]        fill_o [CHANNELS];
  logic [FW-1:0]        fill_i [CHANNELS];
  logic [TICK_BITS-1:0] mem    [DEPTH];

  logic [WB-1:0]        now_w;
  logic [TICK_BITS-1:0] now_t;
  logic                 last_ch;

  // Edge walk signals
  logic [QW-1:0]  e_head;
  logic [FW-1:0]  e_fill;
  logic [7:0]     e_flags;
  logic [7:0]     e_levels;
  logic           e_want;
  logic           e_push;
  logic [PW-1:0]  e_sum;
  logic [PW-1:0]  e_pos;
  logic [FXW-1:0] e_fidx;
  logic [AW-1:0]  waddr;

  // Scan read signals
  logic           mem_re;
  logic [AW-1:0]  raddr;

  // Shared unit operands
  logic [TICK_BITS-1:0] su_a;
  logic [TICK_BITS-1:0] su_b;
  logic [31:0]          su_lim;
  logic                 su_borrow;
  logic                 su_exceeds;

  assign now_w   = WB'(item_q.now);
  assign now_t   = now_w[TICK_BITS-1:0];
  assign last_ch = (ch == CW'(CHANNELS - 1));

  // Push position and write address for the FIFO under the edge walk
  always_comb begin
    e_head   = side ? head_i[ch] : head_o[ch];
    e_fill   = side ? fill_i[ch] : fill_o[ch];
    e_flags  = side ? item_q.flags_inner : item_q.flags_outer;
    e_levels = side ? item_q.levels_inner : item_q.levels_outer;
    e_want   = e_flags[3'(ch)] & ~e_levels[3'(ch)];
    e_push   = e_want && (e_fill < FW'(QUEUE_DEPTH));
    e_sum    = PW'(e_head) + PW'(e_fill);
    e_pos    = (e_sum >= PW'(QUEUE_DEPTH)) ? e_sum - PW'(QUEUE_DEPTH) : e_sum;
    e_fidx   = side ? FXW'(CHANNELS) + FXW'(ch) : FXW'(ch);
    waddr    = AW'(e_fidx) * AW'(QUEUE_DEPTH) + AW'(e_pos);
  end

  // Head read address: outer head, then inner head
  always_comb begin
    mem_re = (state == S_RDO) || (state == S_RDI);
    if (state == S_RDI) begin
      raddr = (AW'(CHANNELS) + AW'(ch)) * AW'(QUEUE_DEPTH) + AW'(head_i[ch]);
    end else begin
      raddr = AW'(ch) * AW'(QUEUE_DEPTH) + AW'(head_o[ch]);
    end
  end

  // Timestamp storage, registered read
  always_ff @(posedge clk) begin
    if (state == S_EDGE && e_push) begin
      mem[waddr] <= now_t;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  // Operand selection for the shared unit
  always_comb begin
    su_a   = to_q;
    su_b   = rdata;
    su_lim = window;
    case (state)
      S_GAP: begin
        su_a = lt ? rdata : to_q;
        su_b = lt ? to_q : rdata;
      end
      S_AGEO: begin
        su_a   = now_t;
        su_b   = to_q;
        su_lim = stale;
      end
      S_AGEI: begin
        su_a   = now_t;
        su_b   = rdata;
        su_lim = stale;
      end
      default: begin
      end
    endcase
  end

  bbpc_ssub #(
    .TICK_BITS(TICK_BITS)
  ) u_ssub (
    .a      (su_a),
    .b      (su_b),
    .lim    (su_lim),
    .borrow (su_borrow),
    .exceeds(su_exceeds)
  );

  // Sequencer and FIFO bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
      side  <= 1'b0;
      total <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        head_o[i] <= '0;
        head_i[i] <= '0;
        fill_o[i] <= '0;
        fill_i[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            ch    <= '0;
            side  <= 1'b0;
            state <= (item.opcode == OP_SCAN) ? S_RDO : S_EDGE;
          end
        end
        S_EDGE: begin
          // Push into one FIFO per cycle, outer side first
          if (e_push) begin
            if (side) begin
              fill_i[ch] <= FW'(fill_i[ch] + 1'b1);
            end else begin
              fill_o[ch] <= FW'(fill_o[ch] + 1'b1);
            end
          end
          if (last_ch) begin
            ch    <= '0;
            side  <= 1'b1;
            state <= side ? S_DONE : S_EDGE;
          end else begin
            ch <= CW'(ch + 1'b1);
          end
        end
        S_RDO: begin
          state <= S_RDI;
        end
        S_RDI: begin
          state <= (fill_o[ch] != '0 && fill_i[ch] != '0) ? S_ORD : S_AGEO;
        end
        S_ORD: begin
          state <= S_GAP;
        end
        S_GAP: begin
          // Pair the heads, or drop the older one outside the window
          if (!su_exceeds) begin
            if (lt) begin
              if (total != '1) begin
                total <= total + 32'd1;
              end
            end else if (total != '0) begin
              total <= total - 32'd1;
            end
          end
          if (!su_exceeds || lt) begin
            head_o[ch] <= (head_o[ch] == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head_o[ch] + 1'b1);
            fill_o[ch] <= FW'(fill_o[ch] - 1'b1);
          end
          if (!su_exceeds || !lt) begin
            head_i[ch] <= (head_i[ch] == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head_i[ch] + 1'b1);
            fill_i[ch] <= FW'(fill_i[ch] - 1'b1);
          end
          ch    <= last_ch ? ch : CW'(ch + 1'b1);
          state <= last_ch ? S_DONE : S_RDO;
        end
        S_AGEO: begin
          // Discard a stale outer head
          if (fill_o[ch] != '0 && su_exceeds) begin
            head_o[ch] <= (head_o[ch] == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head_o[ch] + 1'b1);
            fill_o[ch] <= FW'(fill_o[ch] - 1'b1);
          end
          state <= S_AGEI;
        end
        S_AGEI: begin
          // Discard a stale inner head
          if (fill_i[ch] != '0 && su_exceeds) begin
            head_i[ch] <= (head_i[ch] == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head_i[ch] + 1'b1);
            fill_i[ch] <= FW'(fill_i[ch] - 1'b1);
          end
          ch    <= last_ch ? ch : CW'(ch + 1'b1);
          state <= last_ch ? S_DONE : S_RDO;
        end
        S_DONE: begin
          if (ctl.take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload, drop flags and captured heads
  always_ff @(posedge clk) begin
    if (state == S_IDLE && ctl.start) begin
      item_q <= item;
      drop_o <= '0;
      drop_i <= '0;
    end
    if (state == S_EDGE && e_want && !e_push) begin
      if (side) begin
        drop_i[3'(ch)] <= 1'b1;
      end else begin
        drop_o[3'(ch)] <= 1'b1;
      end
    end
    if (state == S_RDI) begin
      to_q <= rdata;
    end
    if (state == S_ORD) begin
      lt <= su_borrow;
    end
  end

  assign stat.idle         = (state == S_IDLE);
  assign stat.done         = (state == S_DONE);
  assign res.bee_count     = total;
  assign res.dropped_outer = drop_o;
  assign res.dropped_inner = drop_i;

endmodule
